// File: design/psim_pkg.sv
// Package: shared constants, controller states and control structs for the similarity block.
package psim_pkg;

  // Field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CURV_W  = 16;
  localparam int unsigned FLOOR_W = 16;
  localparam int unsigned SIM_W   = 32;
  localparam int unsigned IDX_W   = 2;

  // Accumulator and square widths
  localparam int unsigned NORM_W  = 42;
  localparam int unsigned DIFF_W  = 44;
  localparam int unsigned SQ_W    = 31;
  localparam int unsigned SQD_W   = 32;

  // Datapath widths
  localparam int unsigned PROD_N_W   = CURV_W + NORM_W;   // c * |x|^2
  localparam int unsigned PROD_X_W   = CURV_W + DIFF_W;   // c * |u-v|^2
  localparam int unsigned MAG_W      = 32;                // factor magnitude
  localparam int unsigned PM_W       = 2 * MAG_W;         // factor product, Q.56
  localparam int unsigned DEN_W      = 35;                // denominator, Q.28
  localparam int unsigned QUO_SHIFT  = 5;                 // extra quotient bits
  localparam int unsigned DIVD_W     = PROD_X_W + QUO_SHIFT;
  localparam int unsigned FACT_SHIFT = 12;                // Q.40 down to Q.28
  localparam int unsigned DEN_SHIFT  = 28;                // Q.56 down to Q.28

  // Divider step count and the steps whose quotient bits lie above the output range
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned SAT_STEPS = DIVD_W - SIM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // 1.0 in the Q.40 format of c * |x|^2, and the clamp of a negative factor (8.0 in Q.28)
  localparam logic [PROD_N_W-1:0] BALL_ONE  = PROD_N_W'(64'h100_0000_0000);
  localparam logic [MAG_W-1:0]    MAG_LIMIT = 32'h8000_0000;

  // Register reset values
  localparam logic [CURV_W-1:0]  CURV_RESET  = 16'd4096;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CURVATURE = 2'd0;
  localparam logic [IDX_W-1:0] REG_DEN_FLOOR = 2'd1;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SUM,
    ST_MULT,
    ST_FACT,
    ST_PROD,
    ST_START,
    ST_DIV,
    ST_STORE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic mult_en;
    logic fact_en;
    logic prod_en;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_xfer;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: design/psim_if.sv
// Interfaces: coordinate input channel, result output channel and register write channel.
interface psim_coord_if;
  logic                                valid;
  logic                                ready;
  logic signed [psim_pkg::COORD_W-1:0] u_coord;
  logic signed [psim_pkg::COORD_W-1:0] v_coord;
  logic                                last;

  modport source (output valid, output u_coord, output v_coord, output last, input ready);
  modport sink   (input valid, input u_coord, input v_coord, input last, output ready);
endinterface

interface psim_result_if;
  logic                        valid;
  logic                        ready;
  logic [psim_pkg::SIM_W-1:0]  similarity;
  logic                        saturated;

  modport source (output valid, output similarity, output saturated, input ready);
  modport sink   (input valid, input similarity, input saturated, output ready);
endinterface

interface psim_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [psim_pkg::IDX_W-1:0]   index;
  logic [psim_pkg::CURV_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/psim_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, with output-range saturation.
module psim_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psim_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [psim_pkg::DEN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [psim_pkg::SIM_W-1:0]    quotient_o,
  output logic                          sat_o
);
  import psim_pkg::*;

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIVD_W-1:0]   num_q, num_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [DEN_W:0]      rem_q, rem_d;
  logic [SIM_W-1:0]    quo_q, quo_d;
  logic                sat_q, sat_d;
  logic [DEN_W:0]      trial;
  logic                qbit;
  logic                last_step;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial     = {rem_q[DEN_W-1:0], num_q[DIVD_W-1]};
  assign qbit      = (trial >= {1'b0, den_q});
  assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[DIVD_W-2:0], 1'b0};
      rem_d = qbit ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[SIM_W-2:0], qbit};
      // A quotient bit above the output range flags saturation
      if (qbit && (cnt_q < CNT_W'(SAT_STEPS))) begin
        sat_d = 1'b1;
      end
      if (last_step) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign done_o     = busy_q && last_step;
  assign quotient_o = quo_q;
  assign sat_o      = sat_q;

endmodule

// File: design/psim_datapath.sv
// Datapath: registers, square-and-accumulate, ball factors, denominator, divider, result register.
module psim_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  psim_coord_if.sink              coord_i,
  psim_result_if.source           result_o,
  psim_cfg_if.sink                cfg_i,
  input  psim_pkg::ctrl_cmd_t     cmd_i,
  output psim_pkg::ctrl_status_t  status_o
);
  import psim_pkg::*;

  // Configuration registers
  logic [CURV_W-1:0]  curv_q;
  logic [FLOOR_W-1:0] floor_q;

  // Square stage and accumulators
  logic                      in_xfer;
  logic                      sq_vld_q;
  logic [SQ_W-1:0]           sq_u_q, sq_v_q;
  logic [SQD_W-1:0]          sq_d_q;
  logic signed [2*COORD_W-1:0] u_sq, v_sq;
  logic signed [COORD_W:0]     d_val;
  logic signed [2*COORD_W+1:0] d_sq;
  logic [NORM_W-1:0]         u_sum_q, v_sum_q;
  logic [DIFF_W-1:0]         d_sum_q;
  logic [NORM_W:0]           u_add, v_add;
  logic [DIFF_W:0]           d_add;

  // Factor and denominator stages
  logic [PROD_N_W-1:0] prod_u_q, prod_v_q;
  logic [PROD_X_W-1:0] prod_x_q;
  logic [MAG_W:0]      fact_u, fact_v;
  logic [MAG_W-1:0]    mag_u_q, mag_v_q;
  logic                neg_u_q, neg_v_q;
  logic [PM_W-1:0]     pm_q;
  logic                pos_q;
  logic [DEN_W-1:0]    den_raw, den;
  logic [FLOOR_W-1:0]  floor_eff;

  // Divider and result register
  logic               div_done;
  logic [SIM_W-1:0]   div_quo;
  logic               div_sat;
  logic               out_valid_q;
  logic [SIM_W-1:0]   sim_q;
  logic               sat_q;

  // Factor 1 - c*|x|^2 as sign and magnitude in Q.28; the negative side rounds away
  // from zero (floor of the signed value) and clamps at 8.0
  function automatic logic [MAG_W:0] ball_factor(input logic [PROD_N_W-1:0] prod);
    logic [PROD_N_W-1:0]          ex;
    logic [PROD_N_W-FACT_SHIFT:0] up;
    logic [MAG_W:0]               res;
    if (prod <= BALL_ONE) begin
      ex  = BALL_ONE - prod;
      res = {1'b0, MAG_W'(ex >> FACT_SHIFT)};
    end else begin
      ex = prod - BALL_ONE;
      up = (PROD_N_W-FACT_SHIFT+1)'(ex >> FACT_SHIFT)
         + (PROD_N_W-FACT_SHIFT+1)'(|ex[FACT_SHIFT-1:0]);
      if (up > (PROD_N_W-FACT_SHIFT+1)'(MAG_LIMIT)) begin
        res = {1'b1, MAG_LIMIT};
      end else begin
        res = {1'b1, up[MAG_W-1:0]};
      end
    end
    return res;
  endfunction

  // Take register writes; unknown indexes drop
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curv_q  <= CURV_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CURVATURE: curv_q  <= cfg_i.data;
        REG_DEN_FLOOR: floor_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input handshake
  assign coord_i.ready = cmd_i.in_ready;
  assign in_xfer       = coord_i.valid && cmd_i.in_ready;

  // Square each coordinate and the difference
  assign u_sq  = coord_i.u_coord * coord_i.u_coord;
  assign v_sq  = coord_i.v_coord * coord_i.v_coord;
  assign d_val = (COORD_W+1)'(coord_i.u_coord) - (COORD_W+1)'(coord_i.v_coord);
  assign d_sq  = d_val * d_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_u_q <= u_sq[SQ_W-1:0];
    sq_v_q <= v_sq[SQ_W-1:0];
    sq_d_q <= d_sq[SQD_W-1:0];
  end

  // Add the squares; a carry out saturates the sum at all ones
  assign u_add = {1'b0, u_sum_q} + (NORM_W+1)'(sq_u_q);
  assign v_add = {1'b0, v_sum_q} + (NORM_W+1)'(sq_v_q);
  assign d_add = {1'b0, d_sum_q} + (DIFF_W+1)'(sq_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_sum_q <= '0;
      v_sum_q <= '0;
      d_sum_q <= '0;
    end else if (cmd_i.mult_en) begin
      u_sum_q <= '0;
      v_sum_q <= '0;
      d_sum_q <= '0;
    end else if (sq_vld_q) begin
      u_sum_q <= u_add[NORM_W] ? '1 : u_add[NORM_W-1:0];
      v_sum_q <= v_add[NORM_W] ? '1 : v_add[NORM_W-1:0];
      d_sum_q <= d_add[DIFF_W] ? '1 : d_add[DIFF_W-1:0];
    end
  end

  // Scale the sums by the curvature
  always_ff @(posedge clk_i) begin
    if (cmd_i.mult_en) begin
      prod_u_q <= curv_q * u_sum_q;
      prod_v_q <= curv_q * v_sum_q;
      prod_x_q <= curv_q * d_sum_q;
    end
  end

  // Form both ball factors
  assign fact_u = ball_factor(prod_u_q);
  assign fact_v = ball_factor(prod_v_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fact_en) begin
      neg_u_q <= fact_u[MAG_W];
      mag_u_q <= fact_u[MAG_W-1:0];
      neg_v_q <= fact_v[MAG_W];
      mag_v_q <= fact_v[MAG_W-1:0];
    end
  end

  // Multiply the factor magnitudes; the product is positive when the signs agree
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      pm_q  <= mag_u_q * mag_v_q;
      pos_q <= (neg_u_q == neg_v_q);
    end
  end

  // Bring the product to Q.28 and raise it to the floor
  assign floor_eff = (floor_q == '0) ? FLOOR_W'(1) : floor_q;
  assign den_raw   = pos_q ? DEN_W'(pm_q >> DEN_SHIFT) : '0;
  assign den       = (den_raw < DEN_W'(floor_eff)) ? DEN_W'(floor_eff) : den_raw;

  psim_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({prod_x_q, QUO_SHIFT'(0)}),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .sat_o      (div_sat)
  );

  // Result register: load on a finished division, drop on a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sim_q <= div_sat ? '1 : div_quo;
      sat_q <= div_sat;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.similarity = sim_q;
  assign result_o.saturated  = sat_q;

  // Status to the controller
  assign status_o.last_xfer = in_xfer && coord_i.last;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || result_o.ready;

endmodule

// File: design/psim_ctrl.sv
// Controller: sequences accumulation, the factor and product stages, the division and the result load.
module psim_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psim_pkg::ctrl_status_t  status_i,
  output psim_pkg::ctrl_cmd_t     cmd_o
);
  import psim_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: if (status_i.last_xfer) state_d = ST_SUM;
      ST_SUM:   state_d = ST_MULT;
      ST_MULT:  state_d = ST_FACT;
      ST_FACT:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (status_i.div_done) state_d = ST_STORE;
      ST_STORE: if (status_i.out_free) state_d = ST_ACCUM;
      default:  state_d = ST_ACCUM;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_ACCUM: cmd_o.in_ready  = 1'b1;
      ST_SUM:   ;
      ST_MULT:  cmd_o.mult_en   = 1'b1;
      ST_FACT:  cmd_o.fact_en   = 1'b1;
      ST_PROD:  cmd_o.prod_en   = 1'b1;
      ST_START: cmd_o.div_start = 1'b1;
      ST_DIV:   ;
      ST_STORE: cmd_o.out_load  = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/poincare_similarity_top.sv
// Top level of the Poincare-ball similarity block.
//
//  channel   | dir | transfer                       | payload
//  ----------+-----+--------------------------------+--------------------------------
//  coord_i   | in  | valid && ready                 | u_coord, v_coord, last
//  result_o  | out | valid && ready                 | similarity, saturated
//  cfg_i     | in  | valid && ready (ready always 1) | index, data
//
// Coordinates transfer one per cycle while a vector pair accumulates. After the item
// marked last the block takes no input while it passes the square, scale, factor,
// product and divider load stages, then the bit-serial divider steps, one quotient
// bit each, then the load of the result register.
// Reset clears the state machine, the accumulators, the divider control and the
// registers to their reset values; there is no clearing pass.
// A waiting result sits in the output register while the next pair accumulates; a
// second finished result holds in the divider, with the controller waiting, until that register frees up.
module poincare_similarity_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  psim_coord_if.sink    coord_i,
  psim_result_if.source result_o,
  psim_cfg_if.sink      cfg_i
);
  import psim_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  psim_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  psim_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coord_i  (coord_i),
    .result_o (result_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

// File: dv/similarity_checker.sv
// Checker: watches the channels of the similarity block, predicts each result and compares.
`timescale 1ns / 1ps
module similarity_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  psim_coord_if       coord_i,
  psim_result_if      result_i,
  psim_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import psim_pkg::*;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic             saturated;
  } sim_result_t;

  localparam logic [CURV_W-1:0]  CURV_AT_RESET  = 16'd4096;
  localparam logic [FLOOR_W-1:0] FLOOR_AT_RESET = 16'd1;
  localparam logic [63:0]        UNIT_Q40       = 64'd1 << 40;
  localparam logic [63:0]        ROUND_UP_Q40   = 64'hFFF;
  localparam logic [63:0]        FAR_OUT_CLAMP  = 64'h8000_0000;
  localparam logic [63:0]        NORM_FULL      = (64'd1 << NORM_W) - 64'd1;
  localparam logic [63:0]        DIFF_FULL      = (64'd1 << DIFF_W) - 64'd1;
  localparam logic [69:0]        SIM_FULL       = 70'hFFFF_FFFF;

  logic [CURV_W-1:0]  curvature_q;
  logic [FLOOR_W-1:0] floor_q;
  logic [NORM_W-1:0]  u_norm_q;
  logic [NORM_W-1:0]  v_norm_q;
  logic [DIFF_W-1:0]  diff_norm_q;
  sim_result_t        similarity_due[$];

  // Add a square into a sum of squares, pinned at its all-ones value
  function automatic logic [63:0] add_clamped(input logic [63:0] acc, input logic [63:0] sq,
                                              input logic [63:0] full);
    logic [63:0] sum;
    sum = acc + sq;
    return (sum > full) ? full : sum;
  endfunction

  // 1 - c*|x|^2 in signed Q.28, rounded down; far outside the ball it stops at -8.0
  function automatic logic signed [63:0] ball_scale(input logic [CURV_W-1:0] c,
                                                    input logic [NORM_W-1:0] norm);
    logic [63:0] scaled;
    logic [63:0] mag;
    scaled = 64'(c) * 64'(norm);
    if (scaled <= UNIT_Q40) return $signed((UNIT_Q40 - scaled) >> 12);
    mag = (scaled - UNIT_Q40 + ROUND_UP_Q40) >> 12;
    if (mag > FAR_OUT_CLAMP) mag = FAR_OUT_CLAMP;
    return -$signed(mag);
  endfunction

  // 2c*|u-v|^2 over the floored factor product, Q16.16 rounded down, pinned at full scale
  function automatic sim_result_t predict_similarity(input logic [CURV_W-1:0]  c,
                                                     input logic [FLOOR_W-1:0] fl,
                                                     input logic [NORM_W-1:0]  u_norm,
                                                     input logic [NORM_W-1:0]  v_norm,
                                                     input logic [DIFF_W-1:0]  d_norm);
    logic signed [63:0] fu;
    logic signed [63:0] fv;
    logic signed [63:0] fprod;
    logic [63:0]        den;
    logic [69:0]        num;
    logic [69:0]        quo;
    sim_result_t        res;
    fu    = ball_scale(c, u_norm);
    fv    = ball_scale(c, v_norm);
    fprod = fu * fv;
    den   = (fprod > 0) ? 64'(fprod >>> 28) : 64'd0;
    if (den < 64'(fl)) den = 64'(fl);
    if (den == 64'd0) den = 64'd1;
    num = (70'(c) * 70'(d_norm)) << 5;
    quo = num / 70'(den);
    res.saturated  = (quo > SIM_FULL);
    res.similarity = res.saturated ? '1 : quo[SIM_W-1:0];
    return res;
  endfunction

  // Track registers and sums, queue a prediction per vector pair, check each result transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    longint      u_s;
    longint      v_s;
    longint      d_s;
    logic [63:0] u_next;
    logic [63:0] v_next;
    logic [63:0] d_next;
    sim_result_t got;
    sim_result_t want;
    int unsigned errs;
    if (!rst_ni) begin
      curvature_q  <= CURV_AT_RESET;
      floor_q      <= FLOOR_AT_RESET;
      u_norm_q     <= '0;
      v_norm_q     <= '0;
      diff_norm_q  <= '0;
      similarity_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;

      // register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_CURVATURE: curvature_q <= cfg_i.data;
          REG_DEN_FLOOR: floor_q     <= cfg_i.data;
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (result_i.valid && result_i.ready) begin
        got.similarity = result_i.similarity;
        got.saturated  = result_i.saturated;
        if (similarity_due.size() == 0) begin
          $display("%0t ns: result with nothing predicted, expected none, got %h/%b",
                   $time, got.similarity, got.saturated);
          errs++;
        end else begin
          want = similarity_due.pop_front();
          if (got.similarity !== want.similarity) begin
            $display("%0t ns: similarity mismatch, expected %h, got %h",
                     $time, want.similarity, got.similarity);
            errs++;
          end
          if (got.saturated !== want.saturated) begin
            $display("%0t ns: saturated mismatch, expected %b, got %b",
                     $time, want.saturated, got.saturated);
            errs++;
          end
        end
      end

      // coordinate transfer: accumulate, and on last predict and clear
      if (coord_i.valid && coord_i.ready) begin
        u_s    = longint'(coord_i.u_coord);
        v_s    = longint'(coord_i.v_coord);
        d_s    = u_s - v_s;
        u_next = add_clamped(64'(u_norm_q), 64'(u_s * u_s), NORM_FULL);
        v_next = add_clamped(64'(v_norm_q), 64'(v_s * v_s), NORM_FULL);
        d_next = add_clamped(64'(diff_norm_q), 64'(d_s * d_s), DIFF_FULL);
        if (coord_i.last) begin
          similarity_due.push_back(predict_similarity(curvature_q, floor_q,
                                                      u_next[NORM_W-1:0], v_next[NORM_W-1:0],
                                                      d_next[DIFF_W-1:0]));
          u_norm_q    <= '0;
          v_norm_q    <= '0;
          diff_norm_q <= '0;
        end else begin
          u_norm_q    <= u_next[NORM_W-1:0];
          v_norm_q    <= v_next[NORM_W-1:0];
          diff_norm_q <= d_next[DIFF_W-1:0];
        end
      end

      fail_count_o <= fail_count_o + errs;
      pending_o    <= similarity_due.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the Poincare similarity block.
`timescale 1ns / 1ps
module testbench;
  import psim_pkg::*;

  typedef enum logic [1:0] {
    SPREAD_FULL,
    SPREAD_QUARTER,
    SPREAD_TIGHT,
    SPREAD_CORNER
  } spread_e;

  localparam int unsigned        CYCLE_LIMIT   = 400000;
  localparam int unsigned        DRAIN_CYCLES  = 100;
  localparam int unsigned        CHUNK_ITEMS   = 36;
  localparam int unsigned        CHUNK_VECTORS = 5;
  localparam int unsigned        LONG_VECTOR   = 64;
  localparam logic [IDX_W-1:0]   REG_SPARE_2   = 2'd2;
  localparam logic [IDX_W-1:0]   REG_SPARE_3   = 2'd3;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct  = 20;
  int unsigned recv_stall_pct = 53;
  int unsigned cycle_count    = 0;
  int unsigned fail_count;
  int unsigned pending;

  psim_coord_if  coord_if ();
  psim_result_if result_if ();
  psim_cfg_if    cfg_if ();

  poincare_similarity_top u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .coord_i  (coord_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  similarity_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .coord_i      (coord_if),
    .result_i     (result_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("poincare_similarity_top test failed");
    $finish;
  end

  // Offer one coordinate pair after a random gap; return at the falling edge after its transfer
  task automatic send_coord(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      coord_if.valid <= 1'b0;
      @(negedge clk);
    end
    coord_if.valid   <= 1'b1;
    coord_if.u_coord <= u;
    coord_if.v_coord <= v;
    coord_if.last    <= last;
    @(posedge clk);
    while (!coord_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CURV_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold input, wait out every predicted result and the divider tail
  task automatic drain_results();
    coord_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] random_coord(input spread_e spread);
    case (spread)
      SPREAD_FULL:    return COORD_W'($urandom);
      SPREAD_QUARTER: return COORD_W'($urandom_range(8192) - 4096);
      SPREAD_TIGHT:   return COORD_W'($urandom_range(2048) - 1024);
      default: begin
        case ($urandom_range(6))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          4:       return 16'h0001;
          5:       return 16'h4000;
          default: return 16'hC000;
        endcase
      end
    endcase
  endfunction

  // Mostly short vectors, now and then a long one
  function automatic int unsigned random_length();
    case ($urandom_range(19))
      0:       return $urandom_range(128, 65);
      1, 2:    return $urandom_range(40, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  function automatic logic [CURV_W-1:0] random_curvature();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'd4096;
      4:       return CURV_W'($urandom);
      default: return CURV_W'($urandom_range(8192, 256));
    endcase
  endfunction

  function automatic logic [FLOOR_W-1:0] random_floor();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return FLOOR_W'($urandom);
      default: return FLOOR_W'($urandom_range(255, 1));
    endcase
  endfunction

  task automatic send_random_vector(output int unsigned len);
    spread_e spread;
    len    = random_length();
    spread = spread_e'($urandom_range(3));
    for (int unsigned i = 0; i < len; i++)
      send_coord(random_coord(spread), random_coord(spread), i == len - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned vectors;
    int unsigned len;
    rst_n            = 1'b0;
    coord_if.valid   = 1'b0;
    coord_if.u_coord = '0;
    coord_if.v_coord = '0;
    coord_if.last    = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_CURVATURE;
    cfg_if.data      = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: zero vectors, opposite corners, factor exactly zero,
    // mixed-sign denominator, alternating bits, points far outside the ball
    send_coord(16'h0000, 16'h0000, 1'b1);
    send_coord(16'h7FFF, 16'h8000, 1'b1);
    send_coord(16'h8000, 16'h7FFF, 1'b1);
    send_coord(16'h4000, 16'h0000, 1'b1);
    send_coord(16'h7FFF, 16'h0000, 1'b1);
    send_coord(16'h5555, 16'hAAAA, 1'b0);
    send_coord(16'hAAAA, 16'h5555, 1'b0);
    send_coord(16'h1000, 16'hF000, 1'b1);
    send_coord(16'h0800, 16'h0400, 1'b0);
    send_coord(16'hFFFF, 16'h0001, 1'b0);
    send_coord(16'h0200, 16'hFE00, 1'b1);
    send_coord(16'h7FFF, 16'h7FFF, 1'b0);
    send_coord(16'h8000, 16'h8000, 1'b0);
    send_coord(16'h7FFF, 16'h8000, 1'b1);

    // Zero floor acts as one; then zero curvature gives unit factors
    drain_results();
    write_reg(REG_DEN_FLOOR, 16'd0);
    send_coord(16'h4000, 16'h0000, 1'b1);
    drain_results();
    write_reg(REG_CURVATURE, 16'd0);
    send_coord(16'h7FFF, 16'h8000, 1'b1);
    send_coord(16'h1234, 16'hEDCB, 1'b1);

    // Largest curvature and floor
    drain_results();
    write_reg(REG_CURVATURE, 16'hFFFF);
    write_reg(REG_DEN_FLOOR, 16'hFFFF);
    send_coord(16'h0100, 16'hFF00, 1'b1);
    send_coord(16'h7FFF, 16'h8000, 1'b1);
    send_coord(16'h0010, 16'hFFF0, 1'b1);

    // Spare indexes must change nothing; then a long vector of extreme coordinates
    drain_results();
    write_reg(REG_SPARE_2, CURV_W'($urandom));
    write_reg(REG_SPARE_3, CURV_W'($urandom));
    write_reg(REG_CURVATURE, 16'd1);
    write_reg(REG_DEN_FLOOR, 16'd1);
    send_coord(16'h0001, 16'hFFFF, 1'b1);
    for (int unsigned i = 0; i < LONG_VECTOR; i++)
      send_coord(16'h8000, 16'h7FFF, i == LONG_VECTOR - 1);

    // Random vectors under three idle patterns, registers changed between chunks
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 20;
          recv_stall_pct = 53;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int unsigned chunk = 0; chunk < 4; chunk++) begin
        drain_results();
        write_reg(REG_CURVATURE, random_curvature());
        write_reg(REG_DEN_FLOOR, random_floor());
        sent    = 0;
        vectors = 0;
        while (sent < CHUNK_ITEMS || vectors < CHUNK_VECTORS) begin
          send_random_vector(len);
          sent += len;
          vectors++;
        end
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("poincare_similarity_top test passed");
    end else begin
      $display("poincare_similarity_top test failed");
    end
    $finish;
  end

endmodule
